### src/generational_handle_table_defines.svh
// assertion macros for the generational handle table
`ifndef GENERATIONAL_HANDLE_TABLE_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define GHT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, checked out of reset
`define GHT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define GHT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GHT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### src/ght_pkg.sv
// shared types and constants of the generational handle table
package ght_pkg;

	localparam int unsigned DEFAULT_SLOTS = 1024;
	localparam int unsigned SLOT_BITS     = 16;
	localparam int unsigned GEN_BITS      = 15;
	localparam int unsigned REF_BITS      = 64;
	localparam int unsigned HANDLE_BITS   = 32;

	localparam logic [GEN_BITS-1:0] GEN_LIMIT = 15'h752f;
	localparam logic [GEN_BITS-1:0] GEN_FIRST = 15'h0001;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_REMOVE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_RANGE     = 2'd1,
		STAT_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clear_wr;
		logic load;
		logic commit;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
	} dp_stat_t;

endpackage

### src/ght_ctrl.sv
// sequencer of the handle table: clearing pass, accept, execute
module ght_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  ght_pkg::dp_stat_t dp_stat,
	output ght_pkg::ctl_t     ctl
);

	ght_pkg::state_t state_q, state_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ght_pkg::S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		ctl          = '0;
		s_tready     = 1'b0;
		unique case (state_q)
			ght_pkg::S_CLEAR: begin
				ctl.clear_wr = 1'b1;
				if (dp_stat.clear_last) begin
					state_d = ght_pkg::S_IDLE;
				end
			end
			ght_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.load = 1'b1;
					state_d  = ght_pkg::S_EXEC;
				end
			end
			ght_pkg::S_EXEC: begin
				// wait for room in the output register
				if (!out_valid_q || m_tready) begin
					ctl.commit = 1'b1;
					state_d    = ght_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ght_pkg::S_CLEAR;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule

### src/ght_datapath.sv
// slot memory, free ring, pointers and result register of the handle table
module ght_datapath #(
	parameter int unsigned SLOTS = ght_pkg::DEFAULT_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ght_pkg::ctl_t     ctl,
	output ght_pkg::dp_stat_t dp_stat,
	input  logic [1:0]        s_tuser,
	input  logic [95:0]       s_tdata,
	output logic [1:0]        m_tuser,
	output logic [95:0]       m_tdata
);

	localparam int unsigned SW = $clog2(SLOTS);
	localparam int unsigned CW = $clog2(SLOTS + 1);
	localparam int unsigned GB = ght_pkg::GEN_BITS;
	localparam int unsigned RB = ght_pkg::REF_BITS;
	localparam int unsigned HB = ght_pkg::HANDLE_BITS;
	localparam int unsigned EB = GB + RB;

	// slot entry: tag above reference, tag zero is empty
	logic [EB-1:0] slot_mem [SLOTS];
	logic [SW-1:0] ring_mem [SLOTS];

	logic [1:0]    cmd_q;
	logic [HB-1:0] handle_q;
	logic [RB-1:0] obj_q;
	logic [SW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [GB-1:0] gen_q;
	logic [SW-1:0] clr_q;
	logic [EB-1:0] slot_rd_q;
	logic [SW-1:0] ring_rd_q;

	logic [SW-1:0] rd_idx;
	logic [SW-1:0] h_idx;
	logic [GB-1:0] tag;
	logic [RB-1:0] sref;
	logic          hit;
	logic          ins_ok;
	logic          rem_ok;
	logic          lkp_ok;
	logic [CW:0]   tail_sum;
	logic [CW:0]   tail_wrap;
	logic [SW-1:0] tail;
	logic [SW-1:0] head_nx;
	logic [GB-1:0] gen_inc;
	logic [GB-1:0] gen_nx;
	logic [1:0]    status;

	assign rd_idx = ctl.load ? s_tdata[SW-1:0] : handle_q[SW-1:0];
	assign h_idx  = handle_q[SW-1:0];
	assign tag    = slot_rd_q[EB-1:RB];
	assign sref   = slot_rd_q[RB-1:0];

	assign hit = (handle_q != '1)
		&& ({1'b0, handle_q[ght_pkg::SLOT_BITS-1:0]} < 17'(SLOTS))
		&& (tag != '0)
		&& ({1'b0, tag} == handle_q[HB-1:ght_pkg::SLOT_BITS]);

	assign ins_ok = (cmd_q == ght_pkg::CMD_INSERT) && (obj_q != '0) && (count_q != '0);
	assign lkp_ok = (cmd_q == ght_pkg::CMD_LOOKUP) && hit;
	assign rem_ok = (cmd_q == ght_pkg::CMD_REMOVE) && hit;

	assign tail_sum  = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign tail_wrap = (tail_sum >= (CW+1)'(SLOTS)) ? tail_sum - (CW+1)'(SLOTS) : tail_sum;
	assign tail      = tail_wrap[SW-1:0];

	assign head_nx = (head_q == SW'(SLOTS - 1)) ? '0 : head_q + 1'b1;
	assign gen_inc = gen_q + 1'b1;
	assign gen_nx  = (gen_inc >= ght_pkg::GEN_LIMIT) ? ght_pkg::GEN_FIRST : gen_inc;

	always_comb begin
		unique case (cmd_q) inside
			ght_pkg::CMD_INSERT: status = ins_ok ? ght_pkg::STAT_OK : ght_pkg::STAT_RANGE;
			ght_pkg::CMD_LOOKUP,
			ght_pkg::CMD_REMOVE: status = hit ? ght_pkg::STAT_OK : ght_pkg::STAT_NOT_FOUND;
			default:             status = ght_pkg::STAT_RANGE;
		endcase
	end

	assign dp_stat.clear_last = (clr_q == SW'(SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= CW'(SLOTS);
			gen_q   <= ght_pkg::GEN_FIRST;
			clr_q   <= '0;
		end else begin
			if (ctl.clear_wr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (ctl.commit && ins_ok) begin
				head_q  <= head_nx;
				count_q <= count_q - 1'b1;
				gen_q   <= gen_nx;
			end else if (ctl.commit && rem_ok) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// request fields, held through the execute cycle
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q    <= s_tuser;
			handle_q <= s_tdata[HB-1:0];
			obj_q    <= s_tdata[HB+RB-1:HB];
		end
	end

	always_ff @(posedge clk) begin
		slot_rd_q <= slot_mem[rd_idx];
		if (ctl.clear_wr) begin
			slot_mem[clr_q] <= '0;
		end else if (ctl.commit && ins_ok) begin
			slot_mem[ring_rd_q] <= {gen_q, obj_q};
		end else if (ctl.commit && rem_ok) begin
			slot_mem[h_idx] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		ring_rd_q <= ring_mem[head_q];
		if (ctl.clear_wr) begin
			ring_mem[clr_q] <= clr_q;
		end else if (ctl.commit && rem_ok) begin
			ring_mem[tail] <= h_idx;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			m_tuser         <= status;
			m_tdata[HB-1:0] <= ins_ok ? {1'b0, gen_q, ght_pkg::SLOT_BITS'(ring_rd_q)} : '0;
			m_tdata[95:HB]  <= lkp_ok ? sref : '0;
		end
	end

endmodule

### src/generational_handle_table.sv
// top level of the generational handle table
//
// one request channel (s_*) and one result channel (m_*), both valid/ready
// streams; a word moves on a rising edge with tvalid and tready high
// request word: s_tuser carries the command (insert, lookup, remove), s_tdata
// carries the handle and the object reference; every request gives exactly
// one result word with a status in m_tuser and new handle / found reference
// in m_tdata
// operation: an accepted request goes through a registered read of the
// slot and ring memories and then a write-back step that loads the result
// register; a new request is only taken after the write-back of the last one
// reset: after arst_n releases, a clearing pass writes the free ring with
// 0..SLOTS-1 and empties every slot; s_tready stays low during it
// stall: a finished result waits in the output register while the next
// request is taken and read; its write-back waits until the result register
// is free, so no result is lost or repeated
`include "generational_handle_table_defines.svh"

module generational_handle_table #(
	parameter int unsigned SLOTS = ght_pkg::DEFAULT_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	input  logic [95:0] s_tdata,   // [31:0] handle, [95:32] object_ref
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic [95:0] m_tdata    // [31:0] new_handle, [95:32] found_ref
);

	ght_pkg::ctl_t     ctl;
	ght_pkg::dp_stat_t dp_stat;

	// sequencer: clearing pass, accept, execute
	ght_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.dp_stat  (dp_stat),
		.ctl      (ctl)
	);

	// memories, pointers, generation counter, result register
	ght_datapath #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.dp_stat (dp_stat),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.m_tuser (m_tuser),
		.m_tdata (m_tdata)
	);

	// one request in flight: no accept right after an accept
	`GHT_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// a handle is only issued with an ok status
	`GHT_ASSERT_IMP(a_handle_only_ok, clk, arst_n,
		m_tvalid && (m_tuser != ght_pkg::STAT_OK), m_tdata[31:0] == 32'd0)

	// a reference is only returned with an ok status
	`GHT_ASSERT_IMP(a_ref_only_ok, clk, arst_n,
		m_tvalid && (m_tdata[95:32] != 64'd0), m_tuser == ght_pkg::STAT_OK)

	// a write-back only happens when the result register is free
	`GHT_ASSERT_IMP(a_commit_room, clk, arst_n, ctl.commit, !m_tvalid || m_tready)

endmodule

### tb/sv/tb.sv
// testbench for the generational handle table: scoreboard predictor, stream drivers, watchdog
module tb;

	localparam int unsigned SLOTS          = ght_pkg::DEFAULT_SLOTS;
	localparam int unsigned IDX            = $clog2(SLOTS);
	localparam int unsigned WATCHDOG_LIMIT = 4 * SLOTS + 1000;
	localparam logic [1:0]  CMD_UNUSED     = 2'd3;

	// one result word as the table should return it
	typedef struct packed {
		ght_pkg::status_t status;
		logic [31:0]      new_handle;
		logic [63:0]      found_ref;
	} table_result_t;

	// mirror of the table state; predicts each result word and keeps them in order
	class handle_table_scoreboard;
		bit [IDX-1:0]  free_ring [SLOTS];
		bit [IDX-1:0]  ring_head;
		bit [IDX:0]    free_count;
		bit [14:0]     next_gen;
		bit [63:0]     slot_ref [SLOTS];
		bit [14:0]     slot_tag [SLOTS];
		table_result_t expected_q [$];
		int unsigned   mismatches;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				free_ring[i] = i[IDX-1:0];
				slot_ref[i]  = '0;
				slot_tag[i]  = '0;
			end
			ring_head  = '0;
			free_count = (IDX+1)'(SLOTS);
			next_gen   = ght_pkg::GEN_FIRST;
			mismatches = 0;
		endfunction

		// handle names an occupied slot whose tag equals the generation field
		function bit handle_hits(bit [31:0] h);
			bit [15:0] slot;
			slot = h[15:0];
			if (h == 32'hffff_ffff || slot >= SLOTS)
				return 1'b0;
			if (slot_tag[slot[IDX-1:0]] == '0)
				return 1'b0;
			return {1'b0, slot_tag[slot[IDX-1:0]]} == h[31:16];
		endfunction

		function table_result_t note_request(logic [1:0] cmd, bit [31:0] h, bit [63:0] obj);
			table_result_t r;
			bit [IDX-1:0]  slot;
			bit [IDX-1:0]  tail;
			r.status     = ght_pkg::STAT_RANGE;
			r.new_handle = '0;
			r.found_ref  = '0;
			case (cmd)
				ght_pkg::CMD_INSERT: begin
					if (obj != 0 && free_count != 0) begin
						slot            = free_ring[ring_head];
						r.new_handle    = {1'b0, next_gen, 16'(slot)};
						ring_head       = ring_head + 1'b1;
						free_count      = free_count - 1'b1;
						slot_ref[slot]  = obj;
						slot_tag[slot]  = next_gen;
						next_gen        = next_gen + 1'b1;
						if (next_gen >= ght_pkg::GEN_LIMIT)
							next_gen = ght_pkg::GEN_FIRST;
						r.status = ght_pkg::STAT_OK;
					end
				end
				ght_pkg::CMD_LOOKUP: begin
					if (handle_hits(h)) begin
						r.found_ref = slot_ref[h[IDX-1:0]];
						r.status    = ght_pkg::STAT_OK;
					end else begin
						r.status = ght_pkg::STAT_NOT_FOUND;
					end
				end
				ght_pkg::CMD_REMOVE: begin
					if (handle_hits(h)) begin
						slot            = h[IDX-1:0];
						slot_ref[slot]  = '0;
						slot_tag[slot]  = '0;
						tail            = ring_head + free_count[IDX-1:0];
						free_ring[tail] = slot;
						free_count      = free_count + 1'b1;
						r.status        = ght_pkg::STAT_OK;
					end else begin
						r.status = ght_pkg::STAT_NOT_FOUND;
					end
				end
				default: ;
			endcase
			expected_q.push_back(r);
			return r;
		endfunction

		function void check_result(logic [1:0] st, logic [95:0] data);
			table_result_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: status %0d data %h", st, data);
				return;
			end
			e = expected_q.pop_front();
			if (st !== e.status || data[31:0] !== e.new_handle || data[95:32] !== e.found_ref) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: status %0d/%0d new_handle %h/%h found_ref %h/%h",
						e.status, st, e.new_handle, data[31:0], e.found_ref, data[95:32]);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser = '0;    // [1:0] cmd
	logic [95:0] s_tdata = '0;    // [31:0] handle, [95:32] object_ref
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [1:0]  m_tuser;         // [1:0] status
	logic [95:0] m_tdata;         // [31:0] new_handle, [95:32] found_ref

	handle_table_scoreboard sb = new();
	table_result_t          last_result;
	logic [31:0]            live_handles [$];
	logic [31:0]            stale_handles [$];
	int unsigned            burst_left = 4;
	int unsigned            ready_left = 0;
	int unsigned            idle_cycles = 0;

	generational_handle_table #(.SLOTS(SLOTS)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: check every accepted word, stall in runs of random length
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata);
			if (ready_left == 0) begin
				if ($urandom_range(0, 9) == 0) begin
					m_tready   <= 1'b1;
					ready_left <= $urandom_range(50, 200);
				end else if (m_tready) begin
					m_tready   <= 1'b0;
					ready_left <= $urandom_range(1, 6);
				end else begin
					m_tready   <= 1'b1;
					ready_left <= $urandom_range(1, 10);
				end
			end else begin
				ready_left <= ready_left - 1;
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// drive one request word, note it when taken, then maybe open a gap
	task automatic issue(input logic [1:0] cmd, input logic [31:0] h, input logic [63:0] obj);
		int i;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {obj, h};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		last_result = sb.note_request(cmd, h, obj);
		if (cmd == ght_pkg::CMD_INSERT && last_result.status == ght_pkg::STAT_OK)
			live_handles.push_back(last_result.new_handle);
		if (cmd == ght_pkg::CMD_REMOVE && last_result.status == ght_pkg::STAT_OK) begin
			// newest handles sit at the back, search from there
			for (i = live_handles.size() - 1; i >= 0; i--) begin
				if (live_handles[i] == h) begin
					live_handles.delete(i);
					break;
				end
			end
			stale_handles.push_back(h);
			if (stale_handles.size() > 64)
				void'(stale_handles.pop_front());
		end
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [63:0] random_obj();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 64'h0;
		if (r < 8)
			return 64'hffff_ffff_ffff_ffff;
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] nonnull_obj();
		logic [63:0] obj;
		obj = {$urandom, $urandom};
		if (obj == 0)
			obj = 64'h1;
		return obj;
	endfunction

	// mostly live handles, the rest stale, corrupted, out of range or noise
	function automatic logic [31:0] pick_handle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55 && live_handles.size() != 0)
			return live_handles[$urandom_range(0, live_handles.size() - 1)];
		if (r < 65 && stale_handles.size() != 0)
			return stale_handles[$urandom_range(0, stale_handles.size() - 1)];
		if (r < 72 && live_handles.size() != 0)
			return live_handles[$urandom_range(0, live_handles.size() - 1)]
				^ (32'h1 << $urandom_range(0, 31));
		if (r < 78)
			return 32'hffff_ffff;
		if (r < 85)
			return {16'($urandom), 16'($urandom_range(SLOTS, 16'hffff))};
		return $urandom;
	endfunction

	task automatic random_item(input int insert_pct, input int remove_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			issue(CMD_UNUSED, $urandom, {$urandom, $urandom});
		else if (r < 2 + insert_pct)
			issue(ght_pkg::CMD_INSERT, $urandom, random_obj());
		else if (r < 2 + insert_pct + remove_pct)
			issue(ght_pkg::CMD_REMOVE, pick_handle(), {$urandom, $urandom});
		else
			issue(ght_pkg::CMD_LOOKUP, pick_handle(), {$urandom, $urandom});
	endtask

	initial begin
		logic [31:0] h0;
		logic [31:0] h1;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every command, each miss kind
		issue(ght_pkg::CMD_LOOKUP, 32'hffff_ffff, 64'h0);
		issue(ght_pkg::CMD_INSERT, 32'h0, 64'h0);
		issue(ght_pkg::CMD_INSERT, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
		h0 = last_result.new_handle;
		issue(ght_pkg::CMD_INSERT, 32'h0, 64'h8000_0000_0000_0001);
		h1 = last_result.new_handle;
		issue(ght_pkg::CMD_LOOKUP, h0, 64'hffff_ffff_ffff_ffff);
		issue(ght_pkg::CMD_LOOKUP, h1, 64'h0);
		issue(ght_pkg::CMD_LOOKUP, h0 | 32'h8000_0000, 64'h0);
		issue(ght_pkg::CMD_LOOKUP, {16'h0001, 16'(SLOTS)}, 64'h0);
		issue(ght_pkg::CMD_LOOKUP, {16'h0001, 16'hffff}, 64'h0);
		issue(ght_pkg::CMD_LOOKUP, {16'h0000, 16'h0005}, 64'h0);
		issue(ght_pkg::CMD_LOOKUP, h1 ^ 32'h0001_0000, 64'h0);
		issue(ght_pkg::CMD_REMOVE, 32'hffff_ffff, 64'h0);
		issue(ght_pkg::CMD_REMOVE, {16'h0002, 16'(SLOTS)}, 64'h0);
		issue(ght_pkg::CMD_REMOVE, h0 ^ 32'h0002_0000, 64'h0);
		issue(ght_pkg::CMD_REMOVE, h1, 64'hffff_ffff_ffff_ffff);
		issue(ght_pkg::CMD_REMOVE, h1, 64'h0);
		issue(ght_pkg::CMD_LOOKUP, h1, 64'h0);
		issue(CMD_UNUSED, h0, 64'hffff_ffff_ffff_ffff);
		issue(CMD_UNUSED, 32'h0, 64'h0);
		issue(ght_pkg::CMD_INSERT, 32'h0000_ffff, 64'h1);
		issue(ght_pkg::CMD_LOOKUP, last_result.new_handle, 64'h0);
		issue(ght_pkg::CMD_REMOVE, h0, 64'h0);
		issue(ght_pkg::CMD_LOOKUP, h0, 64'h0);

		// mixed traffic on a lightly filled table
		repeat (40) random_item(45, 20);
		wait_drained();

		// fill the table, then hit it while full
		while (sb.free_count != 0) begin
			if ($urandom_range(0, 49) == 0)
				issue(ght_pkg::CMD_LOOKUP, pick_handle(), {$urandom, $urandom});
			else
				issue(ght_pkg::CMD_INSERT, $urandom, nonnull_obj());
		end
		repeat (6) issue(ght_pkg::CMD_INSERT, $urandom, nonnull_obj());
		issue(ght_pkg::CMD_INSERT, $urandom, 64'h0);

		// drain-heavy mix, slots come back through the ring tail
		repeat (40) random_item(20, 55);

		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
